/* hw/rtl/lci_pkg.sv */
package lci_pkg;

    localparam logic [2:0] OP_TGT_POS  = 3'd0;
    localparam logic [2:0] OP_TGT_VEL  = 3'd1;
    localparam logic [2:0] OP_FF_FORCE = 3'd2;
    localparam logic [2:0] OP_FF_TORQ  = 3'd3;
    localparam logic [2:0] OP_MEASURE  = 3'd4;

    localparam logic [2:0] CFG_ABAD_OFFSET = 3'd0;
    localparam logic [2:0] CFG_HIP_LINK    = 3'd1;
    localparam logic [2:0] CFG_KNEE_LINK   = 3'd2;
    localparam logic [2:0] CFG_GAIN_P      = 3'd3;
    localparam logic [2:0] CFG_GAIN_I      = 3'd4;
    localparam logic [2:0] CFG_GAIN_D      = 3'd5;
    localparam logic [2:0] CFG_INT_LIMIT   = 3'd6;
    localparam logic [2:0] CFG_SIDE_MASK   = 3'd7;

    localparam int KIND_TGT_POS  = 0;
    localparam int KIND_TGT_VEL  = 1;
    localparam int KIND_FF_FORCE = 2;
    localparam int KIND_FF_TORQ  = 3;
    localparam int KIND_INTEGRAL = 4;
    localparam int NUM_KINDS     = 5;

    localparam logic [31:0] INV_TWO_PI_Q32 = 32'd683565276;
    localparam logic [31:0] HALF_PI_Q30    = 32'd1686629713;
    localparam logic [30:0] Q30_ONE        = 31'd1073741824;
    localparam logic [3:0]  SIDE_MASK_RST  = 4'd5;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    function automatic logic [7:0] taylor_div(input logic [2:0] k);
        logic [7:0] d;
        case (k)
            3'd0:    d = 8'd110;
            3'd1:    d = 8'd72;
            3'd2:    d = 8'd42;
            3'd3:    d = 8'd20;
            default: d = 8'd6;
        endcase
        return d;
    endfunction

    function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = S32_MAX;
        else if (v < -64'sd2147483648)
            r = S32_MIN;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        logic signed [32:0] s;
        logic signed [31:0] r;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31])
            r = s[32] ? S32_MIN : S32_MAX;
        else
            r = s[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        logic signed [32:0] s;
        logic signed [31:0] r;
        s = {a[31], a} - {b[31], b};
        if (s[32] != s[31])
            r = s[32] ? S32_MIN : S32_MAX;
        else
            r = s[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] sat_neg(input logic signed [31:0] a);
        logic signed [31:0] r;
        if (a == S32_MIN)
            r = S32_MAX;
        else
            r = -a;
        return r;
    endfunction

endpackage

/* hw/rtl/lci_mem.sv */
module lci_mem #(
    parameter int DEPTH = 20,
    parameter int AW    = 5
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [95:0]   wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [95:0]   rd_data
);

    // A row that was never written reads as zero.
    logic [95:0]      mem [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    logic [95:0]      rd_raw_reg;
    logic             rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_raw_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_raw_reg : '0;

endmodule

/* hw/rtl/lci_qsin.sv */
module lci_qsin #(
    parameter int FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [30:0] u,
    output logic        done,
    output logic [31:0] result
);

    typedef enum logic [2:0] {Q_IDLE, Q_X, Q_X2, Q_T, Q_DIV, Q_S} qstate_t;

    qstate_t     state_reg;
    logic [2:0]  k_reg;
    logic [2:0]  dcnt_reg;
    logic        done_reg;
    logic [30:0] u_reg;
    logic [31:0] x_reg;
    logic [31:0] x2_reg;
    logic [30:0] t_reg;
    logic [39:0] dv_reg;
    logic [6:0]  rem_reg;
    logic [31:0] res_reg;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] prod;
    logic [39:0] dv_next;
    logic [6:0]  rem_next;
    logic [31:0] res_next;

    always_comb
    begin
        case (state_reg)
            Q_X:     begin mul_a = {1'b0, u_reg}; mul_b = lci_pkg::HALF_PI_Q30; end
            Q_X2:    begin mul_a = x_reg;         mul_b = x_reg;               end
            Q_T:     begin mul_a = x2_reg;        mul_b = {1'b0, t_reg};       end
            default: begin mul_a = x_reg;         mul_b = {1'b0, t_reg};       end
        endcase
        prod = 64'(mul_a) * 64'(mul_b);
        res_next = 32'((64'(prod[61:30]) + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
    end

    // Eight quotient bits of the constant division per cycle.
    always_comb
    begin
        logic [7:0] r2;
        logic [7:0] d;
        dv_next  = dv_reg;
        rem_next = rem_reg;
        d        = lci_pkg::taylor_div(k_reg);
        for (int j = 0; j < 8; j++)
        begin
            r2 = {rem_next, dv_next[39]};
            if (r2 >= d)
            begin
                rem_next = 7'(r2 - d);
                dv_next  = {dv_next[38:0], 1'b1};
            end
            else
            begin
                rem_next = r2[6:0];
                dv_next  = {dv_next[38:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= Q_IDLE;
            k_reg     <= '0;
            dcnt_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                Q_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= Q_X;
                    end
                end
                Q_X:
                begin
                    state_reg <= Q_X2;
                end
                Q_X2:
                begin
                    k_reg     <= '0;
                    state_reg <= Q_T;
                end
                Q_T:
                begin
                    dcnt_reg  <= '0;
                    state_reg <= Q_DIV;
                end
                Q_DIV:
                begin
                    dcnt_reg <= dcnt_reg + 3'd1;
                    if (dcnt_reg == 3'd4)
                    begin
                        k_reg     <= k_reg + 3'd1;
                        state_reg <= (k_reg == 3'd4) ? Q_S : Q_T;
                    end
                end
                Q_S:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= Q_IDLE;
                end
                default:
                begin
                    state_reg <= Q_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            Q_IDLE:
            begin
                u_reg <= u;
            end
            Q_X:
            begin
                x_reg <= prod[61:30];
            end
            Q_X2:
            begin
                x2_reg <= prod[61:30];
                t_reg  <= lci_pkg::Q30_ONE;
            end
            Q_T:
            begin
                dv_reg  <= {6'd0, prod[63:30]};
                rem_reg <= '0;
            end
            Q_DIV:
            begin
                dv_reg  <= dv_next;
                rem_reg <= rem_next;
                if (dcnt_reg == 3'd4)
                begin
                    t_reg <= lci_pkg::Q30_ONE - dv_next[30:0];
                end
            end
            Q_S:
            begin
                res_reg <= res_next;
            end
            default:
            begin
            end
        endcase
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

/* hw/rtl/leg_cartesian_impedance_control.sv */
// A write beat leaves the input open; the next beat is accepted in the cycle after it.
// A measurement beat runs three sine/cosine pairs through the quarter-sine unit,
// then 44 steps of the single 32x32 multiplier. No new beat is accepted until its
// result has moved to the output register.
// A finished result waits in the output register while the next beat is accepted.
// Reset clears all stored vectors and the integrals to zero; side_sign_mask resets to 5.
module leg_cartesian_impedance_control #(
    parameter int NUM_LEGS  = 4,
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [30:0]        cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         operation,
    input  logic [1:0]         leg,
    input  logic signed [31:0] vec_a_x,
    input  logic signed [31:0] vec_a_y,
    input  logic signed [31:0] vec_a_z,
    input  logic signed [31:0] rate_abad,
    input  logic signed [31:0] rate_hip,
    input  logic signed [31:0] rate_knee,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         out_leg,
    output logic signed [31:0] torque_abad,
    output logic signed [31:0] torque_hip,
    output logic signed [31:0] torque_knee,
    output logic signed [31:0] foot_x,
    output logic signed [31:0] foot_y,
    output logic signed [31:0] foot_z
);

    localparam int MEM_DEPTH = lci_pkg::NUM_KINDS * NUM_LEGS;
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam logic [5:0] LAST_STEP  = 6'd43;
    localparam logic [5:0] STEP_INTEG = 6'd26;

    typedef enum logic [2:0] {S_IDLE, S_RD, S_ANG, S_PH, S_QA, S_QB, S_MAIN, S_DONE} state_t;

    state_t      state_reg;
    logic [30:0] abad_reg, hip_reg, knee_reg, gp_reg, gi_reg, gd_reg, lim_reg;
    logic [3:0]  mask_reg;
    logic [2:0]  rd_cnt_reg;
    logic [1:0]  idx_reg;
    logic [5:0]  step_reg;
    logic        ph_reg;
    logic        out_valid_reg;

    logic [1:0]         leg_reg;
    logic signed [31:0] ang_reg [3];
    logic signed [31:0] rt_reg [3];
    logic signed [31:0] sn_reg [3];
    logic signed [31:0] cs_reg [3];
    logic signed [31:0] tp_reg [3];
    logic signed [31:0] tv_reg [3];
    logic signed [31:0] ff_reg [3];
    logic signed [31:0] ft_reg [3];
    logic signed [31:0] ig_reg [3];
    logic signed [31:0] err_reg [3];
    logic signed [31:0] ign_reg [3];
    logic signed [31:0] verr_reg [3];
    logic signed [31:0] f_reg [3];
    logic signed [31:0] t_reg [3];
    logic signed [63:0] prod_reg;
    logic [31:0]        phase_reg;
    logic [31:0]        qa_reg;
    logic signed [31:0] d_reg, tmp_reg, c23_reg, s23_reg, a_reg, b_reg, e_reg;
    logic signed [31:0] ab_reg, ef_reg, j10_reg, j11_reg, j12_reg;
    logic signed [31:0] j20_reg, j21_reg, j22_reg, p2_reg, v0_reg, v1_reg, v2_reg;
    logic [1:0]         oleg_reg;
    logic signed [31:0] otq_reg [3];
    logic signed [31:0] oft_reg [3];

    logic               in_fire;
    logic               leg_ok;
    logic               out_load;
    logic               mem_wr_en;
    logic [AW-1:0]      mem_wr_addr;
    logic [95:0]        mem_wr_data;
    logic               mem_rd_en;
    logic [AW-1:0]      mem_rd_addr;
    logic [95:0]        mem_rd_data;
    logic               qs_start;
    logic [30:0]        qs_u;
    logic               qs_done;
    logic [31:0]        qs_res;
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] prod_shr;
    logic signed [31:0] q;
    logic signed [31:0] gp_s, gi_s, gd_s, kl_s, hl_s;
    logic signed [31:0] lim_s;
    logic signed [31:0] p_vec [3];
    logic signed [31:0] v_vec [3];
    logic signed [31:0] ig_new [3];
    logic signed [31:0] err_new [3];

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign leg_ok   = (int'(leg) < NUM_LEGS);
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    assign gp_s  = {1'b0, gp_reg};
    assign gi_s  = {1'b0, gi_reg};
    assign gd_s  = {1'b0, gd_reg};
    assign kl_s  = {1'b0, knee_reg};
    assign hl_s  = {1'b0, hip_reg};
    assign lim_s = {1'b0, lim_reg};

    assign p_vec[0] = ef_reg;
    assign p_vec[1] = j20_reg;
    assign p_vec[2] = p2_reg;
    assign v_vec[0] = v0_reg;
    assign v_vec[1] = v1_reg;
    assign v_vec[2] = v2_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            err_new[i] = lci_pkg::sat_sub(tp_reg[i], p_vec[i]);
            ig_new[i]  = lci_pkg::sat_add(ig_reg[i], err_new[i]);
            if (ig_new[i] > lim_s)
                ig_new[i] = lim_s;
            else if (ig_new[i] < -lim_s)
                ig_new[i] = -lim_s;
        end
    end

    // Memory accesses: write beats, the integral write-back, and the row reads.
    always_comb
    begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = AW'(int'(operation) * NUM_LEGS + int'(leg));
        mem_wr_data = {vec_a_z, vec_a_y, vec_a_x};
        if (in_fire && leg_ok && operation <= lci_pkg::OP_FF_TORQ)
        begin
            mem_wr_en = 1'b1;
        end
        else if (state_reg == S_MAIN && step_reg == STEP_INTEG && ph_reg)
        begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = AW'(lci_pkg::KIND_INTEGRAL * NUM_LEGS + int'(leg_reg));
            mem_wr_data = {ig_new[2], ig_new[1], ig_new[0]};
        end
        mem_rd_en   = (state_reg == S_RD) && (rd_cnt_reg < 3'd5);
        mem_rd_addr = AW'(int'(rd_cnt_reg) * NUM_LEGS + int'(leg_reg));
    end

    lci_mem #(
        .DEPTH(MEM_DEPTH),
        .AW   (AW)
    ) u_mem (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (mem_wr_en),
        .wr_addr(mem_wr_addr),
        .wr_data(mem_wr_data),
        .rd_en  (mem_rd_en),
        .rd_addr(mem_rd_addr),
        .rd_data(mem_rd_data)
    );

    assign qs_start = (state_reg == S_PH) || (state_reg == S_QA && qs_done);
    assign qs_u     = (state_reg == S_PH) ? {1'b0, prod_reg[FRAC_BITS +: 30]}
                                          : lci_pkg::Q30_ONE - {1'b0, phase_reg[29:0]};

    lci_qsin #(
        .FRAC_BITS(FRAC_BITS)
    ) u_qsin (
        .clk   (clk),
        .rst_n (rst_n),
        .start (qs_start),
        .u     (qs_u),
        .done  (qs_done),
        .result(qs_res)
    );

    always_comb
    begin
        mul_a = ang_reg[idx_reg];
        mul_b = lci_pkg::INV_TWO_PI_Q32;
        if (state_reg == S_MAIN)
        begin
            case (step_reg)
                6'd0:    begin mul_a = cs_reg[1]; mul_b = cs_reg[2];   end
                6'd1:    begin mul_a = sn_reg[1]; mul_b = sn_reg[2];   end
                6'd2:    begin mul_a = sn_reg[1]; mul_b = cs_reg[2];   end
                6'd3:    begin mul_a = cs_reg[1]; mul_b = sn_reg[2];   end
                6'd4:    begin mul_a = kl_s;      mul_b = c23_reg;     end
                6'd5:    begin mul_a = hl_s;      mul_b = cs_reg[1];   end
                6'd6:    begin mul_a = kl_s;      mul_b = s23_reg;     end
                6'd7:    begin mul_a = hl_s;      mul_b = sn_reg[1];   end
                6'd8:    begin mul_a = cs_reg[0]; mul_b = ab_reg;      end
                6'd9:    begin mul_a = d_reg;     mul_b = sn_reg[0];   end
                6'd10:   begin mul_a = sn_reg[0]; mul_b = ef_reg;      end
                6'd11:   begin mul_a = sn_reg[0]; mul_b = e_reg;       end
                6'd12:   begin mul_a = sn_reg[0]; mul_b = ab_reg;      end
                6'd13:   begin mul_a = d_reg;     mul_b = cs_reg[0];   end
                6'd14:   begin mul_a = cs_reg[0]; mul_b = ef_reg;      end
                6'd15:   begin mul_a = cs_reg[0]; mul_b = e_reg;       end
                6'd16:   begin mul_a = d_reg;     mul_b = sn_reg[0];   end
                6'd17:   begin mul_a = cs_reg[0]; mul_b = ab_reg;      end
                6'd18:   begin mul_a = ab_reg;    mul_b = rt_reg[1];   end
                6'd19:   begin mul_a = a_reg;     mul_b = rt_reg[2];   end
                6'd20:   begin mul_a = j10_reg;   mul_b = rt_reg[0];   end
                6'd21:   begin mul_a = j11_reg;   mul_b = rt_reg[1];   end
                6'd22:   begin mul_a = j12_reg;   mul_b = rt_reg[2];   end
                6'd23:   begin mul_a = j20_reg;   mul_b = rt_reg[0];   end
                6'd24:   begin mul_a = j21_reg;   mul_b = rt_reg[1];   end
                6'd25:   begin mul_a = j22_reg;   mul_b = rt_reg[2];   end
                6'd27:   begin mul_a = gp_s;      mul_b = err_reg[0];  end
                6'd28:   begin mul_a = gi_s;      mul_b = ign_reg[0];  end
                6'd29:   begin mul_a = gd_s;      mul_b = verr_reg[0]; end
                6'd30:   begin mul_a = gp_s;      mul_b = err_reg[1];  end
                6'd31:   begin mul_a = gi_s;      mul_b = ign_reg[1];  end
                6'd32:   begin mul_a = gd_s;      mul_b = verr_reg[1]; end
                6'd33:   begin mul_a = gp_s;      mul_b = err_reg[2];  end
                6'd34:   begin mul_a = gi_s;      mul_b = ign_reg[2];  end
                6'd35:   begin mul_a = gd_s;      mul_b = verr_reg[2]; end
                6'd36:   begin mul_a = j10_reg;   mul_b = f_reg[1];    end
                6'd37:   begin mul_a = j20_reg;   mul_b = f_reg[2];    end
                6'd38:   begin mul_a = ab_reg;    mul_b = f_reg[0];    end
                6'd39:   begin mul_a = j11_reg;   mul_b = f_reg[1];    end
                6'd40:   begin mul_a = j21_reg;   mul_b = f_reg[2];    end
                6'd41:   begin mul_a = a_reg;     mul_b = f_reg[0];    end
                6'd42:   begin mul_a = j12_reg;   mul_b = f_reg[1];    end
                6'd43:   begin mul_a = j22_reg;   mul_b = f_reg[2];    end
                default: begin mul_a = '0;        mul_b = '0;          end
            endcase
        end
        prod_shr = prod_reg >>> FRAC_BITS;
        q        = lci_pkg::sat64(prod_shr);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            abad_reg      <= '0;
            hip_reg       <= '0;
            knee_reg      <= '0;
            gp_reg        <= '0;
            gi_reg        <= '0;
            gd_reg        <= '0;
            lim_reg       <= '0;
            mask_reg      <= lci_pkg::SIDE_MASK_RST;
            rd_cnt_reg    <= '0;
            idx_reg       <= '0;
            step_reg      <= '0;
            ph_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    lci_pkg::CFG_ABAD_OFFSET: abad_reg <= cfg_wdata;
                    lci_pkg::CFG_HIP_LINK:    hip_reg  <= cfg_wdata;
                    lci_pkg::CFG_KNEE_LINK:   knee_reg <= cfg_wdata;
                    lci_pkg::CFG_GAIN_P:      gp_reg   <= cfg_wdata;
                    lci_pkg::CFG_GAIN_I:      gi_reg   <= cfg_wdata;
                    lci_pkg::CFG_GAIN_D:      gd_reg   <= cfg_wdata;
                    lci_pkg::CFG_INT_LIMIT:   lim_reg  <= cfg_wdata;
                    lci_pkg::CFG_SIDE_MASK:   mask_reg <= cfg_wdata[3:0];
                    default:                  ;
                endcase
            end
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire && leg_ok && operation == lci_pkg::OP_MEASURE)
                    begin
                        rd_cnt_reg <= '0;
                        state_reg  <= S_RD;
                    end
                end
                S_RD:
                begin
                    rd_cnt_reg <= rd_cnt_reg + 3'd1;
                    if (rd_cnt_reg == 3'd5)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_ANG;
                    end
                end
                S_ANG:
                begin
                    state_reg <= S_PH;
                end
                S_PH:
                begin
                    state_reg <= S_QA;
                end
                S_QA:
                begin
                    if (qs_done)
                    begin
                        state_reg <= S_QB;
                    end
                end
                S_QB:
                begin
                    if (qs_done)
                    begin
                        idx_reg <= idx_reg + 2'd1;
                        if (idx_reg == 2'd2)
                        begin
                            step_reg  <= '0;
                            ph_reg    <= 1'b0;
                            state_reg <= S_MAIN;
                        end
                        else
                        begin
                            state_reg <= S_ANG;
                        end
                    end
                end
                S_MAIN:
                begin
                    ph_reg <= !ph_reg;
                    if (ph_reg)
                    begin
                        step_reg <= step_reg + 6'd1;
                        if (step_reg == LAST_STEP)
                        begin
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_DONE:
                begin
                    if (out_load)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            leg_reg    <= leg;
            ang_reg[0] <= vec_a_x;
            ang_reg[1] <= vec_a_y;
            ang_reg[2] <= vec_a_z;
            rt_reg[0]  <= rate_abad;
            rt_reg[1]  <= rate_hip;
            rt_reg[2]  <= rate_knee;
        end
        if (state_reg == S_RD)
        begin
            d_reg <= mask_reg[leg_reg] ? -$signed({1'b0, abad_reg})
                                       : $signed({1'b0, abad_reg});
            for (int i = 0; i < 3; i++)
            begin
                case (rd_cnt_reg)
                    3'd1:    tp_reg[i] <= mem_rd_data[32*i +: 32];
                    3'd2:    tv_reg[i] <= mem_rd_data[32*i +: 32];
                    3'd3:    ff_reg[i] <= mem_rd_data[32*i +: 32];
                    3'd4:    ft_reg[i] <= mem_rd_data[32*i +: 32];
                    3'd5:    ig_reg[i] <= mem_rd_data[32*i +: 32];
                    default: ;
                endcase
            end
        end
        if (state_reg == S_ANG || (state_reg == S_MAIN && !ph_reg))
        begin
            prod_reg <= 64'(mul_a) * 64'(mul_b);
        end
        if (state_reg == S_PH)
        begin
            phase_reg <= prod_reg[FRAC_BITS +: 32];
        end
        if (state_reg == S_QA && qs_done)
        begin
            qa_reg <= qs_res;
        end
        if (state_reg == S_QB && qs_done)
        begin
            case (phase_reg[31:30])
                2'd0:    begin sn_reg[idx_reg] <= qa_reg;  cs_reg[idx_reg] <= qs_res;  end
                2'd1:    begin sn_reg[idx_reg] <= qs_res;  cs_reg[idx_reg] <= -qa_reg; end
                2'd2:    begin sn_reg[idx_reg] <= -qa_reg; cs_reg[idx_reg] <= -qs_res; end
                default: begin sn_reg[idx_reg] <= -qs_res; cs_reg[idx_reg] <= qa_reg;  end
            endcase
        end
        if (state_reg == S_MAIN && ph_reg)
        begin
            case (step_reg)
                6'd0:    tmp_reg <= q;
                6'd1:    c23_reg <= lci_pkg::sat_sub(tmp_reg, q);
                6'd2:    tmp_reg <= q;
                6'd3:    s23_reg <= lci_pkg::sat_add(tmp_reg, q);
                6'd4:    a_reg   <= q;
                6'd5:    b_reg   <= q;
                6'd6:    e_reg   <= q;
                6'd7:
                begin
                    ef_reg <= lci_pkg::sat_add(e_reg, q);
                    ab_reg <= lci_pkg::sat_add(a_reg, b_reg);
                end
                6'd8:    tmp_reg <= q;
                6'd9:    j10_reg <= lci_pkg::sat_sub(tmp_reg, q);
                6'd10:   j11_reg <= lci_pkg::sat_neg(q);
                6'd11:   j12_reg <= lci_pkg::sat_neg(q);
                6'd12:   tmp_reg <= q;
                6'd13:   j20_reg <= lci_pkg::sat_add(tmp_reg, q);
                6'd14:   j21_reg <= q;
                6'd15:   j22_reg <= q;
                6'd16:   tmp_reg <= q;
                6'd17:   p2_reg  <= lci_pkg::sat_sub(tmp_reg, q);
                6'd18:   tmp_reg <= q;
                6'd19:   v0_reg  <= lci_pkg::sat_add(tmp_reg, q);
                6'd20:   tmp_reg <= q;
                6'd21:   tmp_reg <= lci_pkg::sat_add(tmp_reg, q);
                6'd22:   v1_reg  <= lci_pkg::sat_add(tmp_reg, q);
                6'd23:   tmp_reg <= q;
                6'd24:   tmp_reg <= lci_pkg::sat_add(tmp_reg, q);
                6'd25:   v2_reg  <= lci_pkg::sat_add(tmp_reg, q);
                6'd26:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        err_reg[i]  <= err_new[i];
                        ign_reg[i]  <= ig_new[i];
                        verr_reg[i] <= lci_pkg::sat_sub(tv_reg[i], v_vec[i]);
                    end
                end
                6'd27:   tmp_reg  <= lci_pkg::sat_add(ff_reg[0], q);
                6'd28:   tmp_reg  <= lci_pkg::sat_add(tmp_reg, q);
                6'd29:   f_reg[0] <= lci_pkg::sat_add(tmp_reg, q);
                6'd30:   tmp_reg  <= lci_pkg::sat_add(ff_reg[1], q);
                6'd31:   tmp_reg  <= lci_pkg::sat_add(tmp_reg, q);
                6'd32:   f_reg[1] <= lci_pkg::sat_add(tmp_reg, q);
                6'd33:   tmp_reg  <= lci_pkg::sat_add(ff_reg[2], q);
                6'd34:   tmp_reg  <= lci_pkg::sat_add(tmp_reg, q);
                6'd35:   f_reg[2] <= lci_pkg::sat_add(tmp_reg, q);
                6'd36:   tmp_reg  <= lci_pkg::sat_add(ft_reg[0], q);
                6'd37:   t_reg[0] <= lci_pkg::sat_add(tmp_reg, q);
                6'd38:   tmp_reg  <= lci_pkg::sat_add(ft_reg[1], q);
                6'd39:   tmp_reg  <= lci_pkg::sat_add(tmp_reg, q);
                6'd40:   t_reg[1] <= lci_pkg::sat_add(tmp_reg, q);
                6'd41:   tmp_reg  <= lci_pkg::sat_add(ft_reg[2], q);
                6'd42:   tmp_reg  <= lci_pkg::sat_add(tmp_reg, q);
                6'd43:   t_reg[2] <= lci_pkg::sat_add(tmp_reg, q);
                default: ;
            endcase
        end
        if (out_load)
        begin
            oleg_reg <= leg_reg;
            for (int i = 0; i < 3; i++)
            begin
                otq_reg[i] <= t_reg[i];
                oft_reg[i] <= p_vec[i];
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_leg     = oleg_reg;
    assign torque_abad = otq_reg[0];
    assign torque_hip  = otq_reg[1];
    assign torque_knee = otq_reg[2];
    assign foot_x      = oft_reg[0];
    assign foot_y      = oft_reg[1];
    assign foot_z      = oft_reg[2];

endmodule

/* hw/rtl/lci_checker.sv */
module lci_checker #(
    parameter int NUM_LEGS = 4
) (
    input logic               clk,
    input logic               rst_n,
    input logic               cfg_wr_en,
    input logic [2:0]         cfg_index,
    input logic [30:0]        cfg_wdata,
    input logic               in_valid,
    input logic               in_ready,
    input logic [2:0]         operation,
    input logic [1:0]         leg,
    input logic signed [31:0] vec_a_x,
    input logic signed [31:0] vec_a_y,
    input logic signed [31:0] vec_a_z,
    input logic signed [31:0] rate_abad,
    input logic signed [31:0] rate_hip,
    input logic signed [31:0] rate_knee,
    input logic               out_valid,
    input logic               out_ready,
    input logic [1:0]         out_leg,
    input logic signed [31:0] torque_abad,
    input logic signed [31:0] torque_hip,
    input logic signed [31:0] torque_knee,
    input logic signed [31:0] foot_x,
    input logic signed [31:0] foot_y,
    input logic signed [31:0] foot_z
);

    // A result beat held back by the sink keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_leg) && $stable(torque_abad)
            && $stable(torque_hip) && $stable(torque_knee) && $stable(foot_x)
            && $stable(foot_y) && $stable(foot_z))
        else $error("result beat changed while stalled");

    // A measurement beat keeps the input closed in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && operation == lci_pkg::OP_MEASURE
            && int'(leg) < NUM_LEGS |=> !in_ready)
        else $error("input reopened straight after a measurement beat");

    // Write beats never produce a result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid && operation != lci_pkg::OP_MEASURE |=> !out_valid)
        else $error("result appeared after a non-measurement beat");

    // A result always names a leg that exists.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> int'(out_leg) < NUM_LEGS)
        else $error("result for a leg out of range");

endmodule

bind leg_cartesian_impedance_control lci_checker #(.NUM_LEGS(NUM_LEGS)) u_lci_checker (.*);

/* bench/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
    import lci_pkg::*;

    typedef struct packed {
        logic [2:0]         op;
        logic [1:0]         leg;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] az;
        logic signed [31:0] ra;
        logic signed [31:0] rh;
        logic signed [31:0] rk;
    } beat_t;

    typedef struct packed {
        logic [1:0]         leg;
        logic signed [31:0] ta;
        logic signed [31:0] th;
        logic signed [31:0] tk;
        logic signed [31:0] fx;
        logic signed [31:0] fy;
        logic signed [31:0] fz;
    } leg_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [30:0] cfg_wdata = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [2:0] operation = '0;
    logic [1:0] leg = '0;
    logic signed [31:0] vec_a_x = '0, vec_a_y = '0, vec_a_z = '0;
    logic signed [31:0] rate_abad = '0, rate_hip = '0, rate_knee = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [1:0] out_leg;
    logic signed [31:0] torque_abad, torque_hip, torque_knee, foot_x, foot_y, foot_z;

    leg_cartesian_impedance_control u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready),
        .operation(operation), .leg(leg),
        .vec_a_x(vec_a_x), .vec_a_y(vec_a_y), .vec_a_z(vec_a_z),
        .rate_abad(rate_abad), .rate_hip(rate_hip), .rate_knee(rate_knee),
        .out_valid(out_valid), .out_ready(out_ready), .out_leg(out_leg),
        .torque_abad(torque_abad), .torque_hip(torque_hip), .torque_knee(torque_knee),
        .foot_x(foot_x), .foot_y(foot_y), .foot_z(foot_z)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Controller state as the testbench sees it.
    longint tgt_pos[4][3], tgt_vel[4][3], ff_force[4][3], ff_torq[4][3], integ[4][3];
    longint l14, l2, l3, kp, ki, kd, ilim;
    logic [3:0] side_mask;

    beat_t       pending_beats[$];
    leg_result_t expected_results[$];
    int  errors = 0;
    int  mismatches = 0;
    int  beats_sent = 0;
    int  send_gap = 0;
    int  recv_gap = 0;
    bit  hold_sender = 1'b0;

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint fx_mul(longint a, longint b);
        return clamp32((a * b) >>> 16);
    endfunction

    function automatic longint fx_add(longint a, longint b);
        return clamp32(a + b);
    endfunction

    function automatic longint fx_sub(longint a, longint b);
        return clamp32(a - b);
    endfunction

    function automatic longint quarter_sine(longint u);
        longint x, x2, t;
        longint divs[5] = '{110, 72, 42, 20, 6};
        x = (u * 64'd1686629713) >> 30;
        x2 = (x * x) >> 30;
        t = 64'd1073741824;
        for (int k = 0; k < 5; k++)
            t = 64'd1073741824 - ((x2 * t) >> 30) / divs[k];
        return (((x * t) >> 30) + 64'd8192) >> 14;
    endfunction

    task automatic sine_cosine(longint ang, output longint sn, output longint cs);
        longint prod, a, b;
        logic [31:0] phase;
        prod = ang * 64'sd683565276;
        phase = prod[47:16];
        a = quarter_sine(longint'(phase[29:0]));
        b = quarter_sine(64'd1073741824 - longint'(phase[29:0]));
        case (phase[31:30])
            2'd0: begin sn = a; cs = b; end
            2'd1: begin sn = b; cs = -a; end
            2'd2: begin sn = -a; cs = -b; end
            default: begin sn = -b; cs = a; end
        endcase
    endtask

    task automatic predict_leg_torque(beat_t bt);
        longint s[3], c[3], J[3][3], p[3], v[3], F[3], rate[3], ang[3];
        longint d, c23, s23, a, b, e, f, ab, ef, err, ig, verr, fo, t;
        int l;
        leg_result_t r;
        l = bt.leg;
        ang = '{bt.ax, bt.ay, bt.az};
        rate = '{bt.ra, bt.rh, bt.rk};
        if (bt.op == OP_TGT_POS || bt.op == OP_TGT_VEL || bt.op == OP_FF_FORCE ||
            bt.op == OP_FF_TORQ)
        begin
            for (int i = 0; i < 3; i++)
            begin
                case (bt.op)
                    OP_TGT_POS:  tgt_pos[l][i] = ang[i];
                    OP_TGT_VEL:  tgt_vel[l][i] = ang[i];
                    OP_FF_FORCE: ff_force[l][i] = ang[i];
                    default:     ff_torq[l][i] = ang[i];
                endcase
            end
            return;
        end
        if (bt.op != OP_MEASURE)
            return;
        for (int i = 0; i < 3; i++)
            sine_cosine(ang[i], s[i], c[i]);
        d = side_mask[l] ? -l14 : l14;
        c23 = fx_sub(fx_mul(c[1], c[2]), fx_mul(s[1], s[2]));
        s23 = fx_add(fx_mul(s[1], c[2]), fx_mul(c[1], s[2]));
        a = fx_mul(l3, c23);
        b = fx_mul(l2, c[1]);
        e = fx_mul(l3, s23);
        f = fx_mul(l2, s[1]);
        ab = fx_add(a, b);
        ef = fx_add(e, f);
        J[0][0] = 0; J[0][1] = ab; J[0][2] = a;
        J[1][0] = fx_sub(fx_mul(c[0], ab), fx_mul(d, s[0]));
        J[1][1] = clamp32(-fx_mul(s[0], ef));
        J[1][2] = clamp32(-fx_mul(s[0], e));
        J[2][0] = fx_add(fx_mul(s[0], ab), fx_mul(d, c[0]));
        J[2][1] = fx_mul(c[0], ef);
        J[2][2] = fx_mul(c[0], e);
        p[0] = ef;
        p[1] = fx_add(fx_mul(d, c[0]), fx_mul(s[0], ab));
        p[2] = fx_sub(fx_mul(d, s[0]), fx_mul(c[0], ab));
        for (int i = 0; i < 3; i++)
        begin
            v[i] = 0;
            for (int j = 0; j < 3; j++)
                v[i] = fx_add(v[i], fx_mul(J[i][j], rate[j]));
        end
        for (int i = 0; i < 3; i++)
        begin
            err = fx_sub(tgt_pos[l][i], p[i]);
            ig = fx_add(integ[l][i], err);
            if (ig > ilim)
                ig = ilim;
            else if (ig < -ilim)
                ig = -ilim;
            integ[l][i] = ig;
            verr = fx_sub(tgt_vel[l][i], v[i]);
            fo = ff_force[l][i];
            fo = fx_add(fo, fx_mul(kp, err));
            fo = fx_add(fo, fx_mul(ki, ig));
            fo = fx_add(fo, fx_mul(kd, verr));
            F[i] = fo;
        end
        r.leg = bt.leg;
        t = ff_torq[l][0];
        for (int i = 0; i < 3; i++) t = fx_add(t, fx_mul(J[i][0], F[i]));
        r.ta = t;
        t = ff_torq[l][1];
        for (int i = 0; i < 3; i++) t = fx_add(t, fx_mul(J[i][1], F[i]));
        r.th = t;
        t = ff_torq[l][2];
        for (int i = 0; i < 3; i++) t = fx_add(t, fx_mul(J[i][2], F[i]));
        r.tk = t;
        r.fx = p[0];
        r.fy = p[1];
        r.fz = p[2];
        expected_results.push_back(r);
    endtask

    function automatic int pick_gap();
        int g;
        g = $urandom_range(0, 99);
        if (g < 50)
            return 0;
        if (g < 92)
            return $urandom_range(1, 4);
        return $urandom_range(10, 400);
    endfunction

    always @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            predict_leg_torque({operation, leg, vec_a_x, vec_a_y, vec_a_z,
                                rate_abad, rate_hip, rate_knee});
            beats_sent <= beats_sent + 1;
            send_gap <= pick_gap();
        end
        if (!(in_valid && !in_ready))
        begin
            if (!(in_valid && in_ready) && send_gap > 0)
            begin
                in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if ((!(in_valid && in_ready) || pick_gap() == 0) && !hold_sender &&
                     rst_n && pending_beats.size() > 0)
            begin
                beat_t bt;
                bt = pending_beats.pop_front();
                in_valid <= 1'b1;
                {operation, leg, vec_a_x, vec_a_y, vec_a_z,
                 rate_abad, rate_hip, rate_knee} <= bt;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            leg_result_t got;
            got = {out_leg, torque_abad, torque_hip, torque_knee, foot_x, foot_y, foot_z};
            if (expected_results.size() == 0)
            begin
                errors++;
                if (mismatches++ < 10)
                    $display("unexpected result beat %h", got);
            end
            else
            begin
                leg_result_t want;
                want = expected_results.pop_front();
                if (got != want)
                begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("mismatch: leg %0d/%0d tq %0d %0d %0d / %0d %0d %0d foot %0d %0d %0d / %0d %0d %0d",
                                 want.leg, got.leg, want.ta, want.th, want.tk,
                                 got.ta, got.th, got.tk, want.fx, want.fy, want.fz,
                                 got.fx, got.fy, got.fz);
                end
            end
        end
        if (recv_gap > 0)
        begin
            out_ready <= 1'b0;
            recv_gap <= recv_gap - 1;
        end
        else
        begin
            out_ready <= rst_n;
            if (out_valid && out_ready)
                recv_gap <= pick_gap();
        end
    end

    function automatic logic signed [31:0] rand_field();
        case ($urandom_range(0, 5))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return $urandom;
            default: return $signed($urandom_range(0, 32'h0006_4000)) - 32'sh0003_2000;
        endcase
    endfunction

    function automatic beat_t make_beat(logic [2:0] op, logic [1:0] lg);
        beat_t bt;
        bt.op = op;
        bt.leg = lg;
        bt.ax = rand_field();
        bt.ay = rand_field();
        bt.az = rand_field();
        bt.ra = rand_field();
        bt.rh = rand_field();
        bt.rk = rand_field();
        return bt;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [30:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_ABAD_OFFSET: l14 = val;
            CFG_HIP_LINK:    l2 = val;
            CFG_KNEE_LINK:   l3 = val;
            CFG_GAIN_P:      kp = val;
            CFG_GAIN_I:      ki = val;
            CFG_GAIN_D:      kd = val;
            CFG_INT_LIMIT:   ilim = val;
            default:         side_mask = val[3:0];
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_beats.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    task automatic load_settings(int kind);
        logic [30:0] v[7];
        for (int i = 0; i < 7; i++)
        begin
            case (kind)
                0: v[i] = 31'h7FFF_FFFF;
                1: v[i] = 31'd0;
                default: v[i] = (i < 3) ? $urandom_range(31'h0000_4000, 31'h0000_6000) :
                                (i == 6) ? $urandom_range(0, 31'h0010_0000) :
                                $urandom_range(0, 31'h0004_0000);
            endcase
        end
        write_reg(CFG_ABAD_OFFSET, v[0]);
        write_reg(CFG_HIP_LINK, v[1]);
        write_reg(CFG_KNEE_LINK, v[2]);
        write_reg(CFG_GAIN_P, v[3]);
        write_reg(CFG_GAIN_I, v[4]);
        write_reg(CFG_GAIN_D, v[5]);
        write_reg(CFG_INT_LIMIT, v[6]);
        write_reg(CFG_SIDE_MASK, (kind == 0) ? 31'd15 : 31'($urandom_range(0, 15)));
    endtask

    initial
    begin
        beat_t bt;
        for (int l = 0; l < 4; l++)
            for (int i = 0; i < 3; i++)
            begin
                tgt_pos[l][i] = 0; tgt_vel[l][i] = 0; ff_force[l][i] = 0;
                ff_torq[l][i] = 0; integ[l][i] = 0;
            end
        l14 = 0; l2 = 0; l3 = 0; kp = 0; ki = 0; kd = 0; ilim = 0;
        side_mask = SIDE_MASK_RST;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Reset values first, then every operation, unused codes and field extremes.
        for (int op = 0; op < 8; op++)
            pending_beats.push_back(make_beat(op[2:0], op[1:0]));
        bt = '{op: OP_MEASURE, leg: 2'd1, ax: 0, ay: 0, az: 0, ra: 0, rh: 0, rk: 0};
        pending_beats.push_back(bt);
        wait_drained();
        load_settings(2);
        for (int k = 0; k < 12; k++)
            pending_beats.push_back(make_beat((k % 3 == 2) ? OP_MEASURE : k[2:0] & 3'd3,
                                              k[1:0]));
        bt = '{op: OP_MEASURE, leg: 2'd3, ax: 32'sh7FFF_FFFF, ay: 32'sh8000_0000,
               az: 32'sh7FFF_FFFF, ra: 32'sh8000_0000, rh: 32'sh7FFF_FFFF,
               rk: 32'sh8000_0000};
        pending_beats.push_back(bt);
        wait_drained();

        for (int phase = 0; phase < 8; phase++)
        begin
            load_settings(phase == 1 ? 0 : (phase == 2 ? 1 : 2));
            for (int n = 0; n < 200; n++)
            begin
                int sel;
                sel = $urandom_range(0, 99);
                if (sel < 55)
                    bt = make_beat(OP_MEASURE, $urandom_range(0, 3));
                else if (sel < 95)
                    bt = make_beat($urandom_range(0, 3), $urandom_range(0, 3));
                else
                    bt = make_beat($urandom_range(5, 7), $urandom_range(0, 3));
                pending_beats.push_back(bt);
            end
            if (phase == 4)
            begin
                while (pending_beats.size() > 100)
                    @(posedge clk);
                hold_sender = 1'b1;
                while (in_valid || expected_results.size() > 0)
                    @(posedge clk);
                hold_sender = 1'b0;
            end
            wait_drained();
        end

        if (errors == 0)
            $display("** leg_cartesian_impedance_control: PASSED **");
        else
            $display("** leg_cartesian_impedance_control: FAILED **");
        $finish;
    end

    initial
    begin
        #8000000;
        $display("** leg_cartesian_impedance_control: FAILED **");
        $finish;
    end

endmodule
